@@ sv/grouped_linear_feature_embedding_top_assert.svh @@
`ifndef GROUPED_LINEAR_FEATURE_EMBEDDING_TOP_ASSERT_SVH
`define GROUPED_LINEAR_FEATURE_EMBEDDING_TOP_ASSERT_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define GLFE_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off while reset is high
`define GLFE_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/glfe_pkg.sv @@
`timescale 1ns / 1ps

package glfe_pkg;

   localparam int MAX_FEATURES = 8;
   localparam int MAX_VOCAB    = 16;
   localparam int MAX_WIDTH    = 16;
   localparam int VALUE_BITS   = 16;
   localparam int FRAC_BITS    = 12;
   localparam int ACC_BITS     = 40;
   localparam int PROD_BITS    = 2 * VALUE_BITS;

   localparam int FEAT_BITS = 3;
   localparam int POS_BITS  = 4;
   localparam int COL_BITS  = 4;
   localparam int NF_BITS   = 4;
   localparam int NV_BITS   = 5;
   localparam int NW_BITS   = 5;
   localparam int CSR_DATA_BITS  = 5;
   localparam int CSR_INDEX_BITS = 2;

   localparam int W_DEPTH = MAX_FEATURES * MAX_VOCAB * MAX_WIDTH;
   localparam int B_DEPTH = MAX_FEATURES * MAX_WIDTH;
   localparam int W_ADDR_BITS = $clog2(W_DEPTH);
   localparam int B_ADDR_BITS = $clog2(B_DEPTH);

   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 24;
   localparam int REQ_USER_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FEATURES = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VOCAB    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDTH    = 2'd2;

   typedef enum logic [1:0] {
      CMD_LOAD_WEIGHT = 2'd0,
      CMD_LOAD_BIAS   = 2'd1,
      CMD_DATA        = 2'd2
   } cmd_type;

   // controller -> datapath
   typedef struct packed {
      logic                accept;
      logic                mac_issue;
      logic                emit_load;
      logic [COL_BITS-1:0] col;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic                data_ok;
      logic                closes;
      logic [COL_BITS-1:0] col_last;
      logic                pipe_busy;
      logic                out_taken;
   } dp_status_type;

endpackage

@@ sv/glfe_ram.sv @@
`timescale 1ns / 1ps

module glfe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/glfe_ctrl.sv @@
`timescale 1ns / 1ps

module glfe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  glfe_pkg::dp_status_type status,
   output glfe_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   state_type                      state_ff, state_in;
   logic [glfe_pkg::COL_BITS-1:0]  col_ff, col_in;
   logic                           close_ff, close_in;

   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      close_in      = close_ff;
      cmd.accept    = 1'b0;
      cmd.mac_issue = 1'b0;
      cmd.emit_load = 1'b0;
      cmd.col       = col_ff;
      req_tready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (status.data_ok) begin
                  state_in = ST_MAC;
                  col_in   = '0;
                  close_in = status.closes;
               end
            end
         end
         ST_MAC: begin
            cmd.mac_issue = 1'b1;
            if (col_ff == status.col_last) begin
               state_in = ST_DRAIN;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // wait until the last column has been written back
            if (!status.pipe_busy) begin
               if (close_ff) begin
                  cmd.emit_load = 1'b1;
                  cmd.col       = '0;
                  col_in        = '0;
                  state_in      = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            cmd.col = col_ff + 1'b1;
            if (status.out_taken) begin
               if (col_ff == status.col_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.emit_load = 1'b1;
                  col_in        = col_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= '0;
         close_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         close_ff <= close_in;
      end
   end

endmodule

@@ sv/glfe_dp.sv @@
`timescale 1ns / 1ps

module glfe_dp (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic [glfe_pkg::REQ_DATA_BITS-1:0]        req_tdata,
   input  logic [glfe_pkg::REQ_USER_BITS-1:0]        req_tuser,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [glfe_pkg::RSP_DATA_BITS-1:0]        rsp_tdata,
   output logic                                      rsp_tuser,
   output logic                                      rsp_tlast,
   input  logic                                      csr_we,
   input  logic [glfe_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [glfe_pkg::CSR_DATA_BITS-1:0]        csr_wdata,
   input  glfe_pkg::ctrl_cmd_type                    cmd,
   output glfe_pkg::dp_status_type                   status
);

   localparam int FB = glfe_pkg::FEAT_BITS;
   localparam int PB = glfe_pkg::POS_BITS;
   localparam int CB = glfe_pkg::COL_BITS;
   localparam int VB = glfe_pkg::VALUE_BITS;
   localparam int AB = glfe_pkg::ACC_BITS;
   localparam int PRB = glfe_pkg::PROD_BITS;
   localparam int QB = AB + 1 - glfe_pkg::FRAC_BITS;

   // request fields
   logic [FB-1:0]        in_feature;
   logic [PB-1:0]        in_position;
   logic [CB-1:0]        in_column;
   logic signed [VB-1:0] in_value;
   glfe_pkg::cmd_type    in_cmd;

   assign in_feature  = req_tdata[FB-1:0];
   assign in_position = req_tdata[FB+PB-1:FB];
   assign in_column   = req_tdata[FB+PB+CB-1:FB+PB];
   assign in_value    = req_tdata[FB+PB+CB+VB-1:FB+PB+CB];
   assign in_cmd      = glfe_pkg::cmd_type'(req_tuser);

   // configuration registers, raw as written
   logic [glfe_pkg::NF_BITS-1:0] nf_ff;
   logic [glfe_pkg::NV_BITS-1:0] nv_ff;
   logic [glfe_pkg::NW_BITS-1:0] nw_ff;
   logic [glfe_pkg::NF_BITS-1:0] nf;
   logic [glfe_pkg::NV_BITS-1:0] nv;
   logic [glfe_pkg::NW_BITS-1:0] nw;

   always_ff @(posedge clock) begin
      if (reset) begin
         nf_ff <= glfe_pkg::NF_BITS'(glfe_pkg::MAX_FEATURES);
         nv_ff <= glfe_pkg::NV_BITS'(glfe_pkg::MAX_VOCAB);
         nw_ff <= glfe_pkg::NW_BITS'(glfe_pkg::MAX_WIDTH);
      end else if (csr_we) begin
         case (csr_index)
            glfe_pkg::CSR_FEATURES: nf_ff <= csr_wdata[glfe_pkg::NF_BITS-1:0];
            glfe_pkg::CSR_VOCAB:    nv_ff <= csr_wdata[glfe_pkg::NV_BITS-1:0];
            glfe_pkg::CSR_WIDTH:    nw_ff <= csr_wdata[glfe_pkg::NW_BITS-1:0];
            default: ;
         endcase
      end
   end

   // zero reads as one, above max reads as max
   always_comb begin
      nf = nf_ff;
      if (nf_ff == '0) nf = 1;
      else if (nf_ff > glfe_pkg::NF_BITS'(glfe_pkg::MAX_FEATURES))
         nf = glfe_pkg::NF_BITS'(glfe_pkg::MAX_FEATURES);
      nv = nv_ff;
      if (nv_ff == '0) nv = 1;
      else if (nv_ff > glfe_pkg::NV_BITS'(glfe_pkg::MAX_VOCAB))
         nv = glfe_pkg::NV_BITS'(glfe_pkg::MAX_VOCAB);
      nw = nw_ff;
      if (nw_ff == '0) nw = 1;
      else if (nw_ff > glfe_pkg::NW_BITS'(glfe_pkg::MAX_WIDTH))
         nw = glfe_pkg::NW_BITS'(glfe_pkg::MAX_WIDTH);
   end

   logic [glfe_pkg::NV_BITS-1:0] nv_m1;
   logic [glfe_pkg::NW_BITS-1:0] nw_m1;
   assign nv_m1 = nv - 1'b1;
   assign nw_m1 = nw - 1'b1;

   assign status.data_ok = (in_cmd == glfe_pkg::CMD_DATA)
                           && (glfe_pkg::NF_BITS'(in_feature) < nf)
                           && (glfe_pkg::NV_BITS'(in_position) < nv);
   assign status.closes   = (glfe_pkg::NV_BITS'(in_position) == nv_m1);
   assign status.col_last = nw_m1[CB-1:0];

   // item latch
   logic [FB-1:0]        feat_ff;
   logic [PB-1:0]        pos_ff;
   logic signed [VB-1:0] x_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         feat_ff <= in_feature;
         pos_ff  <= in_position;
         x_ff    <= in_value;
      end
   end

   // stores; field widths cover the full store, so loads are always in range
   logic                                w_we, b_we;
   logic [glfe_pkg::W_ADDR_BITS-1:0]    w_waddr, w_raddr;
   logic [glfe_pkg::B_ADDR_BITS-1:0]    b_waddr, b_raddr;
   logic [VB-1:0]                       w_rdata, b_rdata;

   assign w_we    = cmd.accept && (in_cmd == glfe_pkg::CMD_LOAD_WEIGHT);
   assign b_we    = cmd.accept && (in_cmd == glfe_pkg::CMD_LOAD_BIAS);
   assign w_waddr = {in_feature, in_position, in_column};
   assign b_waddr = {in_feature, in_column};
   assign w_raddr = {feat_ff, pos_ff, cmd.col};
   assign b_raddr = {feat_ff, cmd.col};

   glfe_ram #(.WIDTH(VB), .DEPTH(glfe_pkg::W_DEPTH)) u_weight_ram (
      .clock (clock),
      .we    (w_we),
      .waddr (w_waddr),
      .wdata (in_value),
      .raddr (w_raddr),
      .rdata (w_rdata)
   );

   glfe_ram #(.WIDTH(VB), .DEPTH(glfe_pkg::B_DEPTH)) u_bias_ram (
      .clock (clock),
      .we    (b_we),
      .waddr (b_waddr),
      .wdata (in_value),
      .raddr (b_raddr),
      .rdata (b_rdata)
   );

   // MAC pipe: issue -> read data -> product -> accumulate
   logic                  v1_ff, v2_ff;
   logic [CB-1:0]         j1_ff, j2_ff;
   logic signed [PRB-1:0] prod_ff;
   logic [VB-1:0]         bias_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.mac_issue;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      j1_ff   <= cmd.col;
      j2_ff   <= j1_ff;
      prod_ff <= x_ff * $signed(w_rdata);
      bias_ff <= b_rdata;
   end

   assign status.pipe_busy = v1_ff || v2_ff;

   logic [AB-1:0] acc_ff [glfe_pkg::MAX_WIDTH];
   logic [AB-1:0] acc_base;
   logic [AB-1:0] acc_sum;

   always_comb begin
      if (pos_ff == '0) begin
         acc_base = {{(AB-VB-glfe_pkg::FRAC_BITS){bias_ff[VB-1]}}, bias_ff,
                     {glfe_pkg::FRAC_BITS{1'b0}}};
      end else begin
         acc_base = acc_ff[j2_ff];
      end
      acc_sum = acc_base + {{(AB-PRB){prod_ff[PRB-1]}}, prod_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < glfe_pkg::MAX_WIDTH; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (v2_ff) begin
         acc_ff[j2_ff] <= acc_sum;
      end
   end

   // round half up, floor by 2^FRAC, saturate
   logic [AB-1:0]   acc_sel;
   logic [AB:0]     acc_rnd;
   logic [QB-1:0]   q;
   logic            q_sat;
   logic [VB-1:0]   q_val;

   always_comb begin
      acc_sel = acc_ff[cmd.col];
      acc_rnd = {acc_sel[AB-1], acc_sel} + ((AB+1)'(1) << (glfe_pkg::FRAC_BITS - 1));
      q       = acc_rnd[AB:glfe_pkg::FRAC_BITS];
      q_sat   = !((&q[QB-1:VB-1]) || !(|q[QB-1:VB-1]));
      if (!q_sat) q_val = q[VB-1:0];
      else if (q[QB-1]) q_val = {1'b1, {(VB-1){1'b0}}};
      else q_val = {1'b0, {(VB-1){1'b1}}};
   end

   // output register
   logic          rsp_valid_ff;
   logic [FB-1:0] rsp_feat_ff;
   logic [CB-1:0] rsp_col_ff;
   logic [VB-1:0] rsp_val_ff;
   logic          rsp_sat_ff;
   logic          rsp_last_ff;

   assign status.out_taken = rsp_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (status.out_taken) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_feat_ff <= feat_ff;
         rsp_col_ff  <= cmd.col;
         rsp_val_ff  <= q_val;
         rsp_sat_ff  <= q_sat;
         rsp_last_ff <= (cmd.col == nw_m1[CB-1:0]);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_val_ff, rsp_col_ff, rsp_feat_ff};
   assign rsp_tuser  = rsp_sat_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ sv/grouped_linear_feature_embedding_top.sv @@
`timescale 1ns / 1ps
// Load item (weight or bias): written to its store when taken, block ready again next cycle.
// Data item in range: accepted, then the single shared multiply-accumulate steps over
//   the columns in turn, then the block waits until the MAC pipe has written back.
// Closing data item: width_in_use results follow, one per cycle while rsp_tready.
// Reset (synchronous, active high): control idle, accumulators zero, registers
//   8/16/16; weight and bias stores hold whatever until loaded.

module grouped_linear_feature_embedding_top (
   input  logic        clock,
   input  logic        reset,
   // item in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // feature[2:0], position[6:3], column[10:7], value[26:11]
   input  logic [1:0]  req_tuser,  // cmd[1:0]
   // result out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // out_feature[2:0], out_column[6:3], token_value[22:7]
   output logic        rsp_tuser,  // saturated[0]
   output logic        rsp_tlast,  // last column of the token
   // register writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_wdata
);

   `include "grouped_linear_feature_embedding_top_assert.svh"

   // command and status between the sequencer and the datapath
   glfe_pkg::ctrl_cmd_type  ctrl_cmd;
   glfe_pkg::dp_status_type dp_status;

   // sequencer: accept, column sweep, drain, result emission
   glfe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (dp_status),
      .cmd        (ctrl_cmd)
   );

   // datapath: stores, MAC pipe, accumulators, rounding, output register
   glfe_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (ctrl_cmd),
      .status     (dp_status)
   );

   // no new item while a result is pending
   `GLFE_ASSERT_IMP(a_no_accept_during_emit, rsp_tvalid, !req_tready, "item taken while result pending")
   // last result taken -> output empties
   `GLFE_ASSERT_NXT(a_idle_after_last, rsp_tvalid && rsp_tready && rsp_tlast, !rsp_tvalid, "result after last")
   // results are read only once the MAC pipe has written back
   `GLFE_ASSERT_IMP(a_emit_after_drain, ctrl_cmd.emit_load, !dp_status.pipe_busy, "emit with MAC pipe busy")

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

// Stream-level check of the grouped feature embedding block. A behavioral
// copy of the weight/bias stores, column accumulators and register set
// predicts every token element from each accepted item, and the result
// channel is checked against it in order. Test tasks run directed corners,
// heavy output backpressure and random token traffic under several register
// settings.

module testbench;
   import glfe_pkg::*;

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT  = 400_000;
   localparam int         REPORT_LIMIT = 10;
   localparam int         SETTLE_CYCLES = MAX_WIDTH + 8;
   localparam int         TOKEN_MAX    = 2 ** (VALUE_BITS - 1) - 1;
   localparam int         TOKEN_MIN    = -(2 ** (VALUE_BITS - 1));

   typedef struct packed {
      logic [FEAT_BITS-1:0]  feature;
      logic [COL_BITS-1:0]   column;
      logic [VALUE_BITS-1:0] value;
      logic                  saturated;
      logic                  last;
   } token_elem_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [4:0]  csr_wdata = '0;

   // behavioral copy of the block state
   logic [VALUE_BITS-1:0] weight_mem [W_DEPTH];
   logic [VALUE_BITS-1:0] bias_mem [B_DEPTH];
   logic [ACC_BITS-1:0]   col_acc [MAX_WIDTH];
   logic [NF_BITS-1:0]    reg_features = 4'd8;
   logic [NV_BITS-1:0]    reg_vocab = 5'd16;
   logic [NW_BITS-1:0]    reg_width = 5'd16;

   token_elem_t expected_elems[$];

   int unsigned cycle_count = 0;
   int          mismatch_count = 0;
   int          items_accepted = 0;
   int          results_checked = 0;
   int          settings_count = 0;
   bit          no_idle = 1'b0;
   int          rsp_hold_request = 0;
   int          rsp_hold_left = 0;
   int          rsp_stall_left = 0;

   grouped_linear_feature_embedding_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   initial begin
      for (int j = 0; j < MAX_WIDTH; j++) begin
         col_acc[j] = '0;
      end
   end

   function automatic int clamp_count(int v, int maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
   endfunction

   // mostly short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // mostly within +-0.5, some full range, some corner values
   function automatic logic [VALUE_BITS-1:0] rand_value();
      int r;
      int v;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         v = int'($urandom_range(0, 4095)) - 2048;
         return v[VALUE_BITS-1:0];
      end
      if (r < 85) return $urandom();
      case ($urandom_range(0, 4))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'h0001;
         default: return 16'hFFFF;
      endcase
   endfunction

   // Updates the state copy for one accepted item and queues the token
   // elements that a closing data item produces.
   function automatic void accumulate_embedding(logic [1:0] cmd, logic [FEAT_BITS-1:0] feat,
                                                logic [POS_BITS-1:0] pos,
                                                logic [COL_BITS-1:0] col,
                                                logic [VALUE_BITS-1:0] val);
      int nf, nv, nw, wbase;
      logic [VALUE_BITS-1:0] b;
      logic signed [ACC_BITS-1:0] prod;
      logic signed [ACC_BITS:0] rounded;
      token_elem_t elem;
      nf = clamp_count(reg_features, MAX_FEATURES);
      nv = clamp_count(reg_vocab, MAX_VOCAB);
      nw = clamp_count(reg_width, MAX_WIDTH);
      if (cmd == CMD_LOAD_WEIGHT) begin
         weight_mem[(int'(feat) * MAX_VOCAB + int'(pos)) * MAX_WIDTH + int'(col)] = val;
         return;
      end
      if (cmd == CMD_LOAD_BIAS) begin
         bias_mem[int'(feat) * MAX_WIDTH + int'(col)] = val;
         return;
      end
      if (cmd != CMD_DATA || int'(feat) >= nf || int'(pos) >= nv) return;
      wbase = (int'(feat) * MAX_VOCAB + int'(pos)) * MAX_WIDTH;
      for (int j = 0; j < nw; j++) begin
         prod = $signed(val) * $signed(weight_mem[wbase + j]);
         if (pos == 0) begin
            b = bias_mem[int'(feat) * MAX_WIDTH + j];
            col_acc[j] = {{(ACC_BITS - VALUE_BITS - FRAC_BITS){b[VALUE_BITS-1]}}, b,
                          {FRAC_BITS{1'b0}}};
         end
         col_acc[j] = col_acc[j] + prod;
      end
      if (int'(pos) != nv - 1) return;
      for (int j = 0; j < nw; j++) begin
         // round half up, then clip to Q4.12
         rounded = $signed(col_acc[j]) + 2048;
         rounded = rounded >>> FRAC_BITS;
         elem.feature = feat;
         elem.column = j[COL_BITS-1:0];
         elem.saturated = 1'b0;
         elem.last = (j == nw - 1);
         if (rounded > TOKEN_MAX) begin
            elem.value = 16'h7FFF;
            elem.saturated = 1'b1;
         end else if (rounded < TOKEN_MIN) begin
            elem.value = 16'h8000;
            elem.saturated = 1'b1;
         end else begin
            elem.value = rounded[VALUE_BITS-1:0];
         end
         expected_elems.push_back(elem);
      end
   endfunction

   // Entered and left just after a falling edge. With no gap, tvalid stays
   // high for the next call.
   task automatic send_item(logic [1:0] cmd, logic [FEAT_BITS-1:0] feat,
                            logic [POS_BITS-1:0] pos, logic [COL_BITS-1:0] col,
                            logic [VALUE_BITS-1:0] val);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {5'b0, val, col, pos, feat};
      do @(posedge clock); while (!req_tready);
      accumulate_embedding(cmd, feat, pos, col, val);
      items_accepted++;
      gap = no_idle ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_noise();
      case ($urandom_range(0, 3))
         0: send_item(CMD_LOAD_WEIGHT, $urandom_range(0, 7), $urandom_range(0, 15),
                      $urandom_range(0, 15), rand_value());
         1: send_item(CMD_LOAD_BIAS, $urandom_range(0, 7), $urandom_range(0, 15),
                      $urandom_range(0, 15), rand_value());
         2: send_item(CMD_UNUSED, $urandom_range(0, 7), $urandom_range(0, 15),
                      $urandom_range(0, 15), $urandom());
         default: send_item(CMD_DATA, $urandom_range(0, 7), $urandom_range(0, 15),
                            $urandom_range(0, 15), rand_value());
      endcase
   endtask

   // all results in, then room for a data item still in the MAC loop
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (expected_elems.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] index, logic [4:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_FEATURES: reg_features = value[NF_BITS-1:0];
         CSR_VOCAB:    reg_vocab = value;
         CSR_WIDTH:    reg_width = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_config(logic [4:0] features, logic [4:0] vocab, logic [4:0] width);
      settle_block();
      write_reg(CSR_FEATURES, features);
      write_reg(CSR_VOCAB, vocab);
      write_reg(CSR_WIDTH, width);
      csr_we <= 1'b0;
      settings_count++;
   endtask

   // Mostly complete tokens; the rest stop early, plus scattered noise.
   task automatic run_token_traffic(int n_items, bit steady);
      int sent, nf, nv, f, last_pos;
      no_idle = steady;
      nf = clamp_count(reg_features, MAX_FEATURES);
      nv = clamp_count(reg_vocab, MAX_VOCAB);
      sent = 0;
      while (sent < n_items) begin
         f = $urandom_range(0, nf - 1);
         last_pos = ($urandom_range(0, 99) < 80) ? nv - 1 : $urandom_range(0, nv - 1);
         for (int p = 0; p <= last_pos; p++) begin
            if ($urandom_range(0, 99) < 10) send_noise();
            send_item(CMD_DATA, 3'(f), 4'(p), $urandom_range(0, 15), rand_value());
            sent++;
         end
      end
      no_idle = 1'b0;
   endtask

   // fill both stores so no data item ever reads an unwritten entry
   task automatic test_store_preload();
      no_idle = 1'b1;
      for (int f = 0; f < MAX_FEATURES; f++) begin
         for (int c = 0; c < MAX_WIDTH; c++) begin
            send_item(CMD_LOAD_BIAS, 3'(f), 4'($urandom_range(0, 15)), 4'(c), rand_value());
         end
      end
      for (int f = 0; f < MAX_FEATURES; f++) begin
         for (int p = 0; p < MAX_VOCAB; p++) begin
            for (int c = 0; c < MAX_WIDTH; c++) begin
               send_item(CMD_LOAD_WEIGHT, 3'(f), 4'(p), 4'(c), rand_value());
            end
         end
      end
      no_idle = 1'b0;
   endtask

   // registers still at reset values
   task automatic test_reset_defaults();
      run_token_traffic(20, 1'b0);
   endtask

   // Register values outside range, single-position tokens, saturation
   // both ways, rounding at the half point, ignored items.
   task automatic test_register_limits();
      // features 16 keeps only the low 4 bits -> 0 -> one feature;
      // vocab 0 -> one position; width 31 -> full width
      set_config(5'd16, 5'd0, 5'd31);
      send_item(CMD_UNUSED, 3'd0, 4'd0, 4'd0, 16'h1234);
      send_item(CMD_LOAD_WEIGHT, 3'd0, 4'd0, 4'd0, 16'h7FFF);
      send_item(CMD_LOAD_WEIGHT, 3'd0, 4'd0, 4'd1, 16'h8000);
      send_item(CMD_LOAD_WEIGHT, 3'd0, 4'd0, 4'd2, 16'h0001);
      send_item(CMD_LOAD_WEIGHT, 3'd0, 4'd0, 4'd3, 16'hFFFF);
      send_item(CMD_LOAD_BIAS, 3'd0, 4'd0, 4'd0, 16'h7FFF);
      send_item(CMD_LOAD_BIAS, 3'd0, 4'd0, 4'd1, 16'h8000);
      send_item(CMD_LOAD_BIAS, 3'd0, 4'd0, 4'd2, 16'h0000);
      send_item(CMD_LOAD_BIAS, 3'd0, 4'd0, 4'd3, 16'h0800);
      send_item(CMD_DATA, 3'd0, 4'd0, 4'd0, 16'h7FFF);
      send_item(CMD_DATA, 3'd0, 4'd0, 4'd0, 16'h8000);
      send_item(CMD_DATA, 3'd0, 4'd0, 4'd0, 16'h0000);
      // x * 1 lands exactly on the half LSB: +0.5 up, -0.5 up to zero
      send_item(CMD_DATA, 3'd0, 4'd0, 4'd0, 16'h0800);
      send_item(CMD_DATA, 3'd0, 4'd0, 4'd0, 16'hF800);
      // feature beyond count, position beyond count: both dropped
      send_item(CMD_DATA, 3'd1, 4'd0, 4'd0, 16'h1000);
      send_item(CMD_DATA, 3'd0, 4'd3, 4'd0, 16'h1000);
   endtask

   // no start at position 0, restarts, token closed by another feature
   task automatic test_out_of_order_positions();
      // features 15 -> 8, width 1
      set_config(5'd15, 5'd3, 5'd1);
      send_item(CMD_DATA, 3'd2, 4'd1, 4'd5, 16'h1800);
      send_item(CMD_DATA, 3'd2, 4'd2, 4'd9, 16'hE000);
      send_item(CMD_DATA, 3'd5, 4'd0, 4'd0, 16'h7FFF);
      send_item(CMD_DATA, 3'd5, 4'd0, 4'd0, 16'h0400);
      send_item(CMD_DATA, 3'd6, 4'd2, 4'd15, 16'h8000);
      send_item(CMD_DATA, 3'd7, 4'd2, 4'd3, 16'h0C00);
   endtask

   // receiver holds off while every data item closes a full-width token
   task automatic test_output_backpressure();
      set_config(5'd8, 5'd1, 5'd16);
      rsp_hold_request = 500;
      no_idle = 1'b1;
      repeat (10) begin
         send_item(CMD_DATA, $urandom_range(0, 7), 4'd0, $urandom_range(0, 15), rand_value());
      end
      no_idle = 1'b0;
   endtask

   task automatic test_random_traffic();
      set_config(5'd3, 5'd4, 5'd16);
      run_token_traffic(24, 1'b1);
      set_config(5'd8, 5'd2, 5'd5);
      run_token_traffic(22, 1'b0);
      set_config(5'd1, 5'd16, 5'd3);
      run_token_traffic(20, 1'b0);
      set_config($urandom_range(1, 8), $urandom_range(1, 5), $urandom_range(1, 16));
      run_token_traffic(24, 1'b0);
   endtask

   // result-side ready: a requested hold first, then always ready while no_idle, else random stalls
   always @(negedge clock) begin
      if (rsp_hold_request > 0) begin
         rsp_hold_left = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (rsp_hold_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_left--;
      end else if (no_idle) begin
         rsp_tready <= 1'b1;
      end else if (rsp_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left--;
      end else if ($urandom_range(0, 99) < 70) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         rsp_stall_left = pick_gap();
      end
   end

   // compare each token element against the oldest prediction
   always @(posedge clock) begin
      token_elem_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.feature = rsp_tdata[2:0];
         got.column = rsp_tdata[6:3];
         got.value = rsp_tdata[22:7];
         got.saturated = rsp_tuser;
         got.last = rsp_tlast;
         if (expected_elems.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("unexpected element: feat %0d col %0d value %h sat %b last %b",
                        got.feature, got.column, got.value, got.saturated, got.last);
            end
         end else begin
            want = expected_elems.pop_front();
            results_checked++;
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("mismatch: exp feat %0d col %0d value %h sat %b last %b",
                           want.feature, want.column, want.value, want.saturated, want.last);
                  $display("          got feat %0d col %0d value %h sat %b last %b",
                           got.feature, got.column, got.value, got.saturated, got.last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d elements outstanding",
                  cycle_count, expected_elems.size());
         $display("** grouped_linear_feature_embedding_top: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_store_preload();
      test_reset_defaults();
      test_register_limits();
      test_out_of_order_positions();
      test_output_backpressure();
      test_random_traffic();
      settle_block();

      $display("covered %0d items and %0d checked token elements over %0d register settings",
               items_accepted, results_checked, settings_count);
      $display("incl. out-of-range registers, out-of-order positions and a 500-cycle stall");
      if (mismatch_count == 0 && expected_elems.size() == 0) begin
         $display("** grouped_linear_feature_embedding_top: PASSED **");
      end else begin
         $display("%0d mismatches, %0d elements never seen", mismatch_count,
                  expected_elems.size());
         $display("** grouped_linear_feature_embedding_top: FAILED **");
      end
      $finish;
   end

endmodule

@@ grouped_linear_feature_embedding_top.f @@
+incdir+sv
sv/glfe_pkg.sv
sv/glfe_ram.sv
sv/glfe_ctrl.sv
sv/glfe_dp.sv
sv/grouped_linear_feature_embedding_top.sv
test/testbench.sv
